[sv/median_hysteresis_pump_controller_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the pump controller
// Concurrent property wrappers used by the asserting top-level file.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_HYSTERESIS_PUMP_CONTROLLER_DEFINES_SVH
`define MEDIAN_HYSTERESIS_PUMP_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MHPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MHPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mhpc_pkg.sv]
// ----------------------------------------------------------------------------
// mhpc_pkg
// Shared widths, reset values, register indexes and types of the controller.
// ----------------------------------------------------------------------------
package mhpc_pkg;

    localparam int LEVEL_W      = 12;
    localparam int TIME_W       = 32;
    localparam int STEP_W       = 8;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int SAMPLE_COUNT = 7;
    localparam int SAMPLE_WIDTH = 12;

    localparam logic [LEVEL_W-1:0] RST_START_DRY = 12'd1900;
    localparam logic [LEVEL_W-1:0] RST_GAP       = 12'd250;
    localparam logic [TIME_W-1:0]  RST_MIN_ON    = 32'd60000;
    localparam logic [TIME_W-1:0]  RST_MIN_OFF   = 32'd300000;
    localparam logic [TIME_W-1:0]  RST_MAX_ON    = 32'd480000;
    localparam logic [STEP_W-1:0]  RST_STEP      = 8'd10;
    localparam logic [LEVEL_W-1:0] RST_FLOOR     = 12'd200;
    localparam logic [LEVEL_W-1:0] RST_CEILING   = 12'd3900;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_DRY = 3'd0,
        REG_GAP       = 3'd1,
        REG_MIN_ON    = 3'd2,
        REG_MIN_OFF   = 3'd3,
        REG_MAX_ON    = 3'd4,
        REG_STEP      = 3'd5,
        REG_FLOOR     = 3'd6,
        REG_CEILING   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] start_dry;
        logic [LEVEL_W-1:0] gap;
        logic [TIME_W-1:0]  min_on;
        logic [TIME_W-1:0]  min_off;
        logic [TIME_W-1:0]  max_on;
        logic [STEP_W-1:0]  step;
        logic [LEVEL_W-1:0] floor_lvl;
        logic [LEVEL_W-1:0] ceil_lvl;
        logic               load_dry;
    } t_cfg;

    typedef struct packed {
        logic [LEVEL_W-1:0] soil_level;
        logic [LEVEL_W-1:0] dry_level;
        logic               need_water;
        logic               maybe_need_water;
        logic               pump_running;
        logic               safety_cut;
    } t_result;

endpackage

[sv/mhpc_median.sv]
// ----------------------------------------------------------------------------
// mhpc_median
// Median by stable rank: each sample counts the samples ordered before it.
// ----------------------------------------------------------------------------
module mhpc_median #(
    parameter int SAMPLE_COUNT = mhpc_pkg::SAMPLE_COUNT,
    parameter int SAMPLE_WIDTH = mhpc_pkg::SAMPLE_WIDTH
) (
    input  logic [SAMPLE_COUNT-1:0][SAMPLE_WIDTH-1:0] i_samples,
    output logic [SAMPLE_WIDTH-1:0]                   o_median
);

    localparam int RANK_W = $clog2(SAMPLE_COUNT + 1);
    localparam logic [RANK_W-1:0] MID = RANK_W'(SAMPLE_COUNT / 2);

    logic [SAMPLE_COUNT-1:0][RANK_W-1:0] rank;

    always_comb begin
        for (int i = 0; i < SAMPLE_COUNT; i++) begin
            rank[i] = '0;
            for (int j = 0; j < SAMPLE_COUNT; j++) begin
                // equal values: the earlier one sorts first
                if ((i_samples[j] < i_samples[i]) ||
                    ((j < i) && (i_samples[j] == i_samples[i]))) begin
                    rank[i] = rank[i] + RANK_W'(1);
                end
            end
        end
    end

    always_comb begin
        o_median = '0;
        for (int i = 0; i < SAMPLE_COUNT; i++) begin
            if (rank[i] == MID) begin
                o_median = o_median | i_samples[i];
            end
        end
    end

endmodule

[sv/mhpc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// mhpc_cfg_regs
// Configuration register file with write strobe for the threshold reload.
// ----------------------------------------------------------------------------
module mhpc_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [mhpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mhpc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output mhpc_pkg::t_cfg                      o_cfg
);

    mhpc_pkg::t_cfg r_cfg;
    mhpc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg          = r_cfg;
        n_cfg.load_dry = 1'b0;
        if (i_cfg_wr_en) begin
            case (mhpc_pkg::t_cfg_idx'(i_cfg_index))
                mhpc_pkg::REG_START_DRY: begin
                    n_cfg.start_dry = i_cfg_data[mhpc_pkg::LEVEL_W-1:0];
                    n_cfg.load_dry  = 1'b1;
                end
                mhpc_pkg::REG_GAP:     n_cfg.gap       = i_cfg_data[mhpc_pkg::LEVEL_W-1:0];
                mhpc_pkg::REG_MIN_ON:  n_cfg.min_on    = i_cfg_data[mhpc_pkg::TIME_W-1:0];
                mhpc_pkg::REG_MIN_OFF: n_cfg.min_off   = i_cfg_data[mhpc_pkg::TIME_W-1:0];
                mhpc_pkg::REG_MAX_ON:  n_cfg.max_on    = i_cfg_data[mhpc_pkg::TIME_W-1:0];
                mhpc_pkg::REG_STEP:    n_cfg.step      = i_cfg_data[mhpc_pkg::STEP_W-1:0];
                mhpc_pkg::REG_FLOOR:   n_cfg.floor_lvl = i_cfg_data[mhpc_pkg::LEVEL_W-1:0];
                mhpc_pkg::REG_CEILING: n_cfg.ceil_lvl  = i_cfg_data[mhpc_pkg::LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_dry <= mhpc_pkg::RST_START_DRY;
            r_cfg.gap       <= mhpc_pkg::RST_GAP;
            r_cfg.min_on    <= mhpc_pkg::RST_MIN_ON;
            r_cfg.min_off   <= mhpc_pkg::RST_MIN_OFF;
            r_cfg.max_on    <= mhpc_pkg::RST_MAX_ON;
            r_cfg.step      <= mhpc_pkg::RST_STEP;
            r_cfg.floor_lvl <= mhpc_pkg::RST_FLOOR;
            r_cfg.ceil_lvl  <= mhpc_pkg::RST_CEILING;
            r_cfg.load_dry  <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/mhpc_ctrl.sv]
// ----------------------------------------------------------------------------
// mhpc_ctrl
// Threshold adjust, hysteresis compare and pump on/off state machine.
// ----------------------------------------------------------------------------
module mhpc_ctrl #(
    parameter int SAMPLE_WIDTH = mhpc_pkg::SAMPLE_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  mhpc_pkg::t_cfg                  i_cfg,
    input  logic [mhpc_pkg::TIME_W-1:0]     i_now_ms,
    input  logic                            i_raise_press,
    input  logic                            i_lower_press,
    input  logic [SAMPLE_WIDTH-1:0]         i_soil,
    output mhpc_pkg::t_result               o_result
);

    // signed width that holds a sample, a threshold plus step and a negative wet level
    localparam int CW = ((SAMPLE_WIDTH > mhpc_pkg::LEVEL_W) ?
                         SAMPLE_WIDTH : mhpc_pkg::LEVEL_W) + 2;

    typedef enum logic [1:0] {
        PUMP_OFF = 2'b01,
        PUMP_ON  = 2'b10
    } t_pump;

    t_pump                          r_pump, n_pump;
    logic [mhpc_pkg::LEVEL_W-1:0]   r_dry, n_dry;
    logic [mhpc_pkg::TIME_W-1:0]    r_last, n_last;

    logic signed [CW-1:0] lo_s, hi_s, step_s, dry_s, dry_up, dry_dn, soil_s, wet_s;
    logic [mhpc_pkg::TIME_W-1:0] elapsed;
    logic need, maybe, cut;

    function automatic logic signed [CW-1:0] clamp_lvl(
        input logic signed [CW-1:0] x,
        input logic signed [CW-1:0] lo,
        input logic signed [CW-1:0] hi
    );
        logic signed [CW-1:0] y;
        if (x < lo) begin
            y = lo;
        end else if (x > hi) begin
            y = hi;
        end else begin
            y = x;
        end
        return y;
    endfunction

    always_comb begin
        lo_s   = CW'(i_cfg.floor_lvl);
        hi_s   = CW'(i_cfg.ceil_lvl);
        step_s = CW'(i_cfg.step);
        // start from a reloaded threshold that has not landed yet
        dry_s  = i_cfg.load_dry ? CW'(i_cfg.start_dry) : CW'(r_dry);
        dry_up = i_raise_press ? clamp_lvl(dry_s + step_s, lo_s, hi_s) : dry_s;
        dry_dn = i_lower_press ? clamp_lvl(dry_up - step_s, lo_s, hi_s) : dry_up;
        n_dry  = dry_dn[mhpc_pkg::LEVEL_W-1:0];

        soil_s = CW'(i_soil);
        wet_s  = CW'(n_dry) - CW'(i_cfg.gap);
        need   = soil_s > CW'(n_dry);
        maybe  = (soil_s > wet_s) && !need;

        elapsed = i_now_ms - r_last;
        n_pump  = r_pump;
        n_last  = r_last;
        cut     = 1'b0;
        case (r_pump)
            PUMP_OFF: begin
                if ((elapsed >= i_cfg.min_off) && need) begin
                    n_pump = PUMP_ON;
                    n_last = i_now_ms;
                end
            end
            PUMP_ON: begin
                if (elapsed >= i_cfg.max_on) begin
                    n_pump = PUMP_OFF;
                    n_last = i_now_ms;
                    cut    = 1'b1;
                end else if ((elapsed >= i_cfg.min_on) && (soil_s < wet_s)) begin
                    n_pump = PUMP_OFF;
                    n_last = i_now_ms;
                end
            end
            default: begin
                n_pump = PUMP_OFF;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pump <= PUMP_OFF;
            r_dry  <= mhpc_pkg::RST_START_DRY;
            r_last <= '0;
        end else if (i_step) begin
            r_pump <= n_pump;
            r_dry  <= n_dry;
            r_last <= n_last;
        end else if (i_cfg.load_dry) begin
            r_dry <= i_cfg.start_dry;
        end
    end

    assign o_result.soil_level       = mhpc_pkg::LEVEL_W'(i_soil);
    assign o_result.dry_level        = n_dry;
    assign o_result.need_water       = need;
    assign o_result.maybe_need_water = maybe;
    assign o_result.pump_running     = (n_pump == PUMP_ON);
    assign o_result.safety_cut       = cut;

endmodule

[sv/median_hysteresis_pump_controller.sv]
// An accepted request is captured in the input register; its result is then captured in the
// result register, which drives the result outputs.
// Throughput: one request per cycle; the median, threshold and pump logic sits between
// the input register and the result register; a held result stalls input once both fill.
// Reset (synchronous, active low): pipeline empty, pump off, switch time 0,
// dry threshold and all configuration registers at their default values.
// ----------------------------------------------------------------------------
// median_hysteresis_pump_controller
// Soil moisture pump controller: median filter, hysteresis, min on/off times.
// ----------------------------------------------------------------------------
`include "median_hysteresis_pump_controller_defines.svh"

module median_hysteresis_pump_controller #(
    parameter int SAMPLE_WIDTH = mhpc_pkg::SAMPLE_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [mhpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mhpc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [mhpc_pkg::TIME_W-1:0]       i_now_ms,
    input  logic                              i_raise_press,
    input  logic                              i_lower_press,
    input  logic [SAMPLE_WIDTH-1:0]           i_sample_0,
    input  logic [SAMPLE_WIDTH-1:0]           i_sample_1,
    input  logic [SAMPLE_WIDTH-1:0]           i_sample_2,
    input  logic [SAMPLE_WIDTH-1:0]           i_sample_3,
    input  logic [SAMPLE_WIDTH-1:0]           i_sample_4,
    input  logic [SAMPLE_WIDTH-1:0]           i_sample_5,
    input  logic [SAMPLE_WIDTH-1:0]           i_sample_6,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [mhpc_pkg::LEVEL_W-1:0]      o_soil_level,
    output logic [mhpc_pkg::LEVEL_W-1:0]      o_dry_level,
    output logic                              o_need_water,
    output logic                              o_maybe_need_water,
    output logic                              o_pump_running,
    output logic                              o_safety_cut
);

    logic [mhpc_pkg::SAMPLE_COUNT-1:0][SAMPLE_WIDTH-1:0] samples;
    logic [SAMPLE_WIDTH-1:0] median;
    mhpc_pkg::t_cfg    cfg;
    mhpc_pkg::t_result result;

    logic                          r_in_vld;
    logic [mhpc_pkg::TIME_W-1:0]   r_now;
    logic                          r_raise, r_lower;
    logic [mhpc_pkg::SAMPLE_COUNT-1:0][SAMPLE_WIDTH-1:0] r_samples;
    logic                          r_out_vld;
    mhpc_pkg::t_result             r_res;

    logic advance, accept, step;

    assign samples = {i_sample_6, i_sample_5, i_sample_4, i_sample_3,
                      i_sample_2, i_sample_1, i_sample_0};

    mhpc_median #(
        .SAMPLE_COUNT (mhpc_pkg::SAMPLE_COUNT),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_median (
        .i_samples (r_samples),
        .o_median  (median)
    );

    mhpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // result register frees up when empty or taken this cycle
    assign advance    = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_in_vld || advance;
    assign accept     = i_in_valid && o_in_ready;
    assign step       = r_in_vld && advance;

    mhpc_ctrl #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_cfg         (cfg),
        .i_now_ms      (r_now),
        .i_raise_press (r_raise),
        .i_lower_press (r_lower),
        .i_soil        (median),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now     <= i_now_ms;
            r_raise   <= i_raise_press;
            r_lower   <= i_lower_press;
            r_samples <= samples;
        end
        if (step) begin
            r_res <= result;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_soil_level       = r_res.soil_level;
    assign o_dry_level        = r_res.dry_level;
    assign o_need_water       = r_res.need_water;
    assign o_maybe_need_water = r_res.maybe_need_water;
    assign o_pump_running     = r_res.pump_running;
    assign o_safety_cut       = r_res.safety_cut;

    `MHPC_ASSERT_NOW(a_cut_stops_pump, i_clk, i_rst_n, o_out_valid && o_safety_cut, !o_pump_running, "safety cut with pump still running")
    `MHPC_ASSERT_NOW(a_need_excl_maybe, i_clk, i_rst_n, o_out_valid, !(o_need_water && o_maybe_need_water), "need and maybe both set")
    `MHPC_ASSERT_NEXT(a_step_lands, i_clk, i_rst_n, step, o_out_valid, "stepped request did not reach result register")

endmodule

[sim/median_hysteresis_pump_controller_tb.sv]
// ----------------------------------------------------------------------------
// median_hysteresis_pump_controller_tb
// Self-checking bench for the soil moisture pump controller. Control steps go
// in through a valid/ready driver, and each result is compared field by field
// with a cycle-free model of the threshold, median and pump logic. The run
// covers directed corner steps, then random phases under several register
// settings, with random idle bursts and one long output hold.
// ----------------------------------------------------------------------------
module median_hysteresis_pump_controller_tb;

    localparam int SW  = mhpc_pkg::SAMPLE_WIDTH;
    localparam int NS  = mhpc_pkg::SAMPLE_COUNT;
    localparam int MID = NS / 2;

    typedef struct packed {
        logic [mhpc_pkg::TIME_W-1:0] now;
        logic                        raise;
        logic                        lower;
        logic [NS-1:0][SW-1:0]       smp;
    } t_ctrl_step;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_wr_en = 1'b0;
    logic [mhpc_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [mhpc_pkg::CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic [mhpc_pkg::TIME_W-1:0]        i_now_ms = '0;
    logic                               i_raise_press = 1'b0;
    logic                               i_lower_press = 1'b0;
    logic [SW-1:0]                      i_sample_0 = '0;
    logic [SW-1:0]                      i_sample_1 = '0;
    logic [SW-1:0]                      i_sample_2 = '0;
    logic [SW-1:0]                      i_sample_3 = '0;
    logic [SW-1:0]                      i_sample_4 = '0;
    logic [SW-1:0]                      i_sample_5 = '0;
    logic [SW-1:0]                      i_sample_6 = '0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic [mhpc_pkg::LEVEL_W-1:0]       o_soil_level;
    logic [mhpc_pkg::LEVEL_W-1:0]       o_dry_level;
    logic                               o_need_water;
    logic                               o_maybe_need_water;
    logic                               o_pump_running;
    logic                               o_safety_cut;

    median_hysteresis_pump_controller DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_now_ms           (i_now_ms),
        .i_raise_press      (i_raise_press),
        .i_lower_press      (i_lower_press),
        .i_sample_0         (i_sample_0),
        .i_sample_1         (i_sample_1),
        .i_sample_2         (i_sample_2),
        .i_sample_3         (i_sample_3),
        .i_sample_4         (i_sample_4),
        .i_sample_5         (i_sample_5),
        .i_sample_6         (i_sample_6),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_soil_level       (o_soil_level),
        .o_dry_level        (o_dry_level),
        .o_need_water       (o_need_water),
        .o_maybe_need_water (o_maybe_need_water),
        .o_pump_running     (o_pump_running),
        .o_safety_cut       (o_safety_cut)
    );

    // ------------------------------------------------------------------
    // Controller model: registers and kept state
    // ------------------------------------------------------------------
    logic [mhpc_pkg::LEVEL_W-1:0] cfg_start   = mhpc_pkg::RST_START_DRY;
    logic [mhpc_pkg::LEVEL_W-1:0] cfg_gap     = mhpc_pkg::RST_GAP;
    logic [mhpc_pkg::TIME_W-1:0]  cfg_min_on  = mhpc_pkg::RST_MIN_ON;
    logic [mhpc_pkg::TIME_W-1:0]  cfg_min_off = mhpc_pkg::RST_MIN_OFF;
    logic [mhpc_pkg::TIME_W-1:0]  cfg_max_on  = mhpc_pkg::RST_MAX_ON;
    logic [mhpc_pkg::STEP_W-1:0]  cfg_step    = mhpc_pkg::RST_STEP;
    logic [mhpc_pkg::LEVEL_W-1:0] cfg_floor   = mhpc_pkg::RST_FLOOR;
    logic [mhpc_pkg::LEVEL_W-1:0] cfg_ceiling = mhpc_pkg::RST_CEILING;

    logic [mhpc_pkg::LEVEL_W-1:0] thr_dry     = mhpc_pkg::RST_START_DRY;
    logic                         pump_on     = 1'b0;
    logic [mhpc_pkg::TIME_W-1:0]  last_switch = '0;

    int pump_starts = 0;
    int cap_cuts    = 0;

    function automatic logic [SW-1:0] median_level(input logic [NS-1:0][SW-1:0] s);
        int i, j, lt, le;
        for (i = 0; i < NS; i++) begin
            lt = 0;
            le = 0;
            for (j = 0; j < NS; j++) begin
                if (s[j] < s[i]) lt++;
                if (s[j] <= s[i]) le++;
            end
            // the middle rank falls inside this value's run of equals
            if (lt <= MID && le > MID) return s[i];
        end
        return '0;
    endfunction

    function automatic int clamp_level(input int v);
        if (v < int'(cfg_floor)) return int'(cfg_floor);
        if (v > int'(cfg_ceiling)) return int'(cfg_ceiling);
        return v;
    endfunction

    function automatic mhpc_pkg::t_result predict_step(input t_ctrl_step st);
        int                           dry, soil, wet;
        logic [mhpc_pkg::TIME_W-1:0]  elapsed;
        mhpc_pkg::t_result            r;
        dry = int'(thr_dry);
        if (st.raise) dry = clamp_level(dry + int'(cfg_step));
        if (st.lower) dry = clamp_level(dry - int'(cfg_step));
        thr_dry = dry[mhpc_pkg::LEVEL_W-1:0];
        dry = int'(thr_dry);
        soil = int'(median_level(st.smp));
        wet = dry - int'(cfg_gap);

        r.soil_level = soil[mhpc_pkg::LEVEL_W-1:0];
        r.dry_level = thr_dry;
        r.need_water = (soil > dry);
        r.maybe_need_water = (soil > wet) && !r.need_water;
        r.safety_cut = 1'b0;

        elapsed = st.now - last_switch;
        if (!pump_on) begin
            if (elapsed >= cfg_min_off && r.need_water) begin
                pump_on = 1'b1;
                last_switch = st.now;
                pump_starts++;
            end
        end else if ((elapsed >= cfg_min_on && soil < wet) || elapsed >= cfg_max_on) begin
            pump_on = 1'b0;
            last_switch = st.now;
            r.safety_cut = (elapsed >= cfg_max_on);
            if (r.safety_cut) cap_cuts++;
        end
        r.pump_running = pump_on;
        return r;
    endfunction

    function automatic void apply_reg(input mhpc_pkg::t_cfg_idx idx,
                                      input logic [mhpc_pkg::CFG_DATA_W-1:0] d);
        case (idx)
            mhpc_pkg::REG_START_DRY: begin
                cfg_start = d[mhpc_pkg::LEVEL_W-1:0];
                thr_dry = d[mhpc_pkg::LEVEL_W-1:0];
            end
            mhpc_pkg::REG_GAP:     cfg_gap     = d[mhpc_pkg::LEVEL_W-1:0];
            mhpc_pkg::REG_MIN_ON:  cfg_min_on  = d[mhpc_pkg::TIME_W-1:0];
            mhpc_pkg::REG_MIN_OFF: cfg_min_off = d[mhpc_pkg::TIME_W-1:0];
            mhpc_pkg::REG_MAX_ON:  cfg_max_on  = d[mhpc_pkg::TIME_W-1:0];
            mhpc_pkg::REG_STEP:    cfg_step    = d[mhpc_pkg::STEP_W-1:0];
            mhpc_pkg::REG_FLOOR:   cfg_floor   = d[mhpc_pkg::LEVEL_W-1:0];
            mhpc_pkg::REG_CEILING: cfg_ceiling = d[mhpc_pkg::LEVEL_W-1:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    t_ctrl_step        pending_steps[$];
    mhpc_pkg::t_result expected_results[$];
    t_ctrl_step        cur_step;
    bit                calm = 1'b0;
    int                send_gap = 0;
    int                steps_done = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(predict_step(cur_step));
                steps_done++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 6) == 0) begin
                    send_gap = $urandom_range(0, 2);
                    i_in_valid <= 1'b0;
                end else if (pending_steps.size() > 0) begin
                    cur_step = pending_steps.pop_front();
                    i_now_ms      <= cur_step.now;
                    i_raise_press <= cur_step.raise;
                    i_lower_press <= cur_step.lower;
                    i_sample_0    <= cur_step.smp[0];
                    i_sample_1    <= cur_step.smp[1];
                    i_sample_2    <= cur_step.smp[2];
                    i_sample_3    <= cur_step.smp[3];
                    i_sample_4    <= cur_step.smp[4];
                    i_sample_5    <= cur_step.smp[5];
                    i_sample_6    <= cur_step.smp[6];
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result ready: random stall bursts plus one long hold
    // ------------------------------------------------------------------
    int taken_cnt  = 0;
    int hold_left  = 0;
    int stall_left = 0;
    bit hold_done  = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) taken_cnt++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && taken_cnt >= 600) begin
                // hold long enough for the pipeline to back up into the input
                hold_done = 1'b1;
                hold_left = 79;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 2);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    int                mismatches = 0;
    mhpc_pkg::t_result want;

    task automatic report_field(input string fld, input logic [31:0] exp_v,
                                input logic [31:0] got_v);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, exp_v, got_v);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: result with no request waiting, expected none, actual soil %0d dry %0d",
                         $time, o_soil_level, o_dry_level);
            end else begin
                want = expected_results.pop_front();
                if (o_soil_level !== want.soil_level)
                    report_field("soil_level", 32'(want.soil_level), 32'(o_soil_level));
                if (o_dry_level !== want.dry_level)
                    report_field("dry_level", 32'(want.dry_level), 32'(o_dry_level));
                if (o_need_water !== want.need_water)
                    report_field("need_water", 32'(want.need_water), 32'(o_need_water));
                if (o_maybe_need_water !== want.maybe_need_water)
                    report_field("maybe_need_water", 32'(want.maybe_need_water),
                                 32'(o_maybe_need_water));
                if (o_pump_running !== want.pump_running)
                    report_field("pump_running", 32'(want.pump_running),
                                 32'(o_pump_running));
                if (o_safety_cut !== want.safety_cut)
                    report_field("safety_cut", 32'(want.safety_cut), 32'(o_safety_cut));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    int                          missing  = 0;
    int                          settings = 0;
    logic [mhpc_pkg::TIME_W-1:0] clock_ms = '0;

    task automatic add_step(input logic [mhpc_pkg::TIME_W-1:0] t, input logic r,
                            input logic l, input logic [NS-1:0][SW-1:0] s);
        t_ctrl_step st;
        st.now = t;
        st.raise = r;
        st.lower = l;
        st.smp = s;
        pending_steps.push_back(st);
    endtask

    // wait until every request went in and every result came back
    task automatic wait_idle();
        int n;
        n = 0;
        do begin
            @(negedge i_clk);
            n++;
        end while ((pending_steps.size() != 0 || i_in_valid || expected_results.size() != 0)
                   && n < 20000);
        if (n >= 20000) begin
            missing++;
            $display("%0t: results missing, expected %0d more, actual none", $time,
                     expected_results.size());
        end
    endtask

    task automatic reg_write(input mhpc_pkg::t_cfg_idx idx,
                             input logic [mhpc_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        apply_reg(idx, val);
    endtask

    task automatic reg_close();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        settings++;
    endtask

    // set random bits above the register width; the block must drop them
    function automatic logic [mhpc_pkg::CFG_DATA_W-1:0] junk_above(
        input logic [mhpc_pkg::CFG_DATA_W-1:0] v,
        input int w
    );
        logic [mhpc_pkg::CFG_DATA_W-1:0] j;
        j = $urandom();
        return (w >= mhpc_pkg::CFG_DATA_W) ? v : (v | (j << w));
    endfunction

    task automatic set_regs(input int start_v, input int gap_v, input logic [31:0] on_v,
                            input logic [31:0] off_v, input logic [31:0] cap_v,
                            input int step_v, input int floor_v, input int ceil_v);
        reg_write(mhpc_pkg::REG_GAP,       junk_above(gap_v, mhpc_pkg::LEVEL_W));
        reg_write(mhpc_pkg::REG_MIN_ON,    on_v);
        reg_write(mhpc_pkg::REG_MIN_OFF,   off_v);
        reg_write(mhpc_pkg::REG_MAX_ON,    cap_v);
        reg_write(mhpc_pkg::REG_STEP,      junk_above(step_v, mhpc_pkg::STEP_W));
        reg_write(mhpc_pkg::REG_FLOOR,     junk_above(floor_v, mhpc_pkg::LEVEL_W));
        reg_write(mhpc_pkg::REG_CEILING,   junk_above(ceil_v, mhpc_pkg::LEVEL_W));
        reg_write(mhpc_pkg::REG_START_DRY, junk_above(start_v, mhpc_pkg::LEVEL_W));
        reg_close();
    endtask

    // soil readings wander around the threshold so all three bands are hit
    task automatic queue_steps(input int count, input int max_adv);
        int          n, k, c, d;
        t_ctrl_step  st;
        c = int'(thr_dry);
        for (n = 0; n < count; n++) begin
            clock_ms += $urandom_range(0, max_adv);
            if ($urandom_range(0, 49) == 0) clock_ms = $urandom();
            if ($urandom_range(0, 9) == 0)
                c = int'(thr_dry) + int'($urandom_range(0, 800)) - 400;
            else
                c = c + int'($urandom_range(0, 120)) - 60;
            if (c < 0) c = 0;
            if (c > 4095) c = 4095;
            st.now = clock_ms;
            st.raise = ($urandom_range(0, 3) == 0);
            st.lower = ($urandom_range(0, 3) == 0);
            for (k = 0; k < NS; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    st.smp[k] = SW'($urandom_range(0, (1 << SW) - 1));
                end else begin
                    d = c + int'($urandom_range(0, 100)) - 50;
                    if (d < 0) d = 0;
                    if (d > (1 << SW) - 1) d = (1 << SW) - 1;
                    st.smp[k] = d[SW-1:0];
                end
            end
            pending_steps.push_back(st);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: extremes of the samples, every press combination,
        // pump on, normal off, safety cut, time wrap and time going back
        add_step(32'd0,        1'b0, 1'b0, {7{12'd0}});
        add_step(32'd1000,     1'b0, 1'b0, {7{12'd4095}});
        add_step(32'd299999,   1'b0, 1'b0, {12'd4095, 12'd0, 12'd4095, 12'd0,
                                            12'd4095, 12'd0, 12'd2000});
        add_step(32'd300000,   1'b0, 1'b0, {12'd4095, 12'd0, 12'd4095, 12'd0,
                                            12'd4095, 12'd0, 12'd2000});
        add_step(32'd300001,   1'b1, 1'b0, {7{12'd1800}});
        add_step(32'd360001,   1'b0, 1'b1, {7{12'd1649}});
        add_step(32'd360002,   1'b1, 1'b1, {7{12'd1650}});
        add_step(32'd660002,   1'b0, 1'b0, {7{12'd1901}});
        add_step(32'd1140001,  1'b0, 1'b0, {7{12'd1700}});
        add_step(32'd1140002,  1'b0, 1'b0, {7{12'd1700}});
        add_step(32'hFFFF_FFF0, 1'b0, 1'b0, {7{12'd4095}});
        add_step(32'h0000_0010, 1'b0, 1'b0, {7{12'd0}});
        add_step(32'd59984,    1'b0, 1'b0, {7{12'd0}});
        add_step(32'd59000,    1'b0, 1'b0, {7{12'd4000}});
        add_step(32'd59001,    1'b0, 1'b0, {12'd7, 12'd3, 12'd3, 12'd9, 12'd1, 12'd9, 12'd5});
        add_step(32'd59002,    1'b1, 1'b0, {12'd4095, 12'd4094, 12'd1, 12'd2, 12'd3,
                                            12'd2048, 12'd2047});
        wait_idle();

        // clamp at the ceiling
        reg_write(mhpc_pkg::REG_START_DRY, 32'd3895);
        reg_close();
        add_step(32'd2000000,  1'b1, 1'b0, {7{12'd3000}});
        add_step(32'd2000001,  1'b1, 1'b0, {7{12'd3000}});
        add_step(32'd2000002,  1'b0, 1'b1, {7{12'd3000}});
        wait_idle();

        // clamp at the floor
        reg_write(mhpc_pkg::REG_START_DRY, 32'd205);
        reg_close();
        add_step(32'd2000003,  1'b0, 1'b1, {7{12'd100}});
        add_step(32'd2000004,  1'b1, 1'b1, {7{12'd100}});
        wait_idle();

        // floor above ceiling, then negative wet threshold and zero cap
        reg_write(mhpc_pkg::REG_FLOOR,     32'd3000);
        reg_write(mhpc_pkg::REG_CEILING,   32'd1000);
        reg_write(mhpc_pkg::REG_START_DRY, 32'd2000);
        reg_close();
        add_step(32'd2000005,  1'b1, 1'b0, {7{12'd2500}});
        add_step(32'd2000006,  1'b1, 1'b0, {7{12'd2500}});
        add_step(32'd2000007,  1'b0, 1'b1, {7{12'd2500}});
        wait_idle();
        reg_write(mhpc_pkg::REG_GAP,     32'd4095);
        reg_write(mhpc_pkg::REG_MAX_ON,  32'd0);
        reg_write(mhpc_pkg::REG_MIN_OFF, 32'd0);
        reg_close();
        add_step(32'd2000008,  1'b0, 1'b0, {7{12'd4095}});
        add_step(32'd2000009,  1'b0, 1'b0, {7{12'd0}});
        add_step(32'd2000010,  1'b0, 1'b0, {7{12'd4095}});
        wait_idle();

        clock_ms = 32'd3000000;

        // default values, real-time scale
        set_regs(1900, 250, 32'd60000, 32'd300000, 32'd480000, 10, 200, 3900);
        queue_steps(300, 40000);
        wait_idle();

        // short times so the pump cycles often; the long hold lands here
        set_regs($urandom_range(1000, 3000), 300, 32'd20, 32'd40, 32'd150, 25, 500, 3500);
        queue_steps(350, 12);
        wait_idle();

        // zero times, widest gap and step, full clamp range
        set_regs(0, 4095, 32'd0, 32'd0, 32'd0, 255, 0, 4095);
        queue_steps(250, 3);
        wait_idle();

        // all-ones times, zero gap and step, floor at top and ceiling at zero
        set_regs(4095, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 4095, 0);
        queue_steps(200, 32'h7FFF_FFFF);
        wait_idle();

        // random settings
        set_regs($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 200),
                 $urandom_range(0, 200), $urandom_range(0, 400), $urandom_range(0, 255),
                 $urandom_range(0, 2000), $urandom_range(2000, 4095));
        queue_steps(300, 50);
        wait_idle();

        // final stretch with no idling on either side
        calm = 1'b1;
        set_regs(1900, 250, 32'd10, 32'd10, 32'd60, 10, 200, 3900);
        queue_steps(300, 8);
        wait_idle();
        repeat (6) @(posedge i_clk);

        $display("summary: %0d control steps checked over %0d register settings",
                 steps_done, settings);
        $display("summary: pump started %0d times, %0d safety cuts, long output hold %0s",
                 pump_starts, cap_cuts, hold_done ? "done" : "not reached");
        if (mismatches == 0 && missing == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

[median_hysteresis_pump_controller.f]
+incdir+sv
sv/mhpc_pkg.sv
sv/mhpc_median.sv
sv/mhpc_cfg_regs.sv
sv/mhpc_ctrl.sv
sv/median_hysteresis_pump_controller.sv
sim/median_hysteresis_pump_controller_tb.sv
